// ----- src/pfm_pkg.sv -----
package pfm_pkg;

	// Fixed widths and counts used across the monitor
	localparam int LEVEL_W    = 12;
	localparam int TICKS_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int KIND_W     = 2;
	localparam int FAULT_W    = 4;
	localparam int NUM_DET    = 4;
	localparam int OUT_DATA_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIG_LIMIT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRV_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UV_TRIP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UV_RECOVER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OC_DEBOUNCE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UV_DEBOUNCE   = 3'd5;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DRIVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LIDAR = 2'd2;

	// Detector slots, also the fault bit positions
	localparam int DET_SIG_OC = 0;
	localparam int DET_DRV_OC = 1;
	localparam int DET_SIG_UV = 2;
	localparam int DET_DRV_UV = 3;

	// Result beat layout above the fault bits
	localparam int OUT_DRV_EN_BIT = 4;
	localparam int OUT_LIDAR_BIT  = 5;

	typedef struct packed {
		logic [LEVEL_W-1:0] sig_limit;
		logic [LEVEL_W-1:0] drv_limit;
		logic [LEVEL_W-1:0] trip_level;
		logic [LEVEL_W-1:0] recover_level;
		logic [TICKS_W-1:0] oc_ticks;
		logic [TICKS_W-1:0] uv_ticks;
	} pfm_cfg_t;

	typedef struct packed {
		logic state;
		logic next_state;
	} det_status_t;

endpackage

// ----- src/pfm_cfg_regs.sv -----
module pfm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfm_pkg::CFG_DATA_W-1:0] cfg_data,
	output pfm_pkg::pfm_cfg_t              cfg
);
	import pfm_pkg::*;

	pfm_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sig_limit     <= {LEVEL_W{1'b1}};
			cfg_q.drv_limit     <= {LEVEL_W{1'b1}};
			cfg_q.trip_level    <= '0;
			cfg_q.recover_level <= '0;
			cfg_q.oc_ticks      <= '0;
			cfg_q.uv_ticks      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIG_LIMIT:   cfg_q.sig_limit     <= cfg_data[LEVEL_W-1:0];
				REG_DRV_LIMIT:   cfg_q.drv_limit     <= cfg_data[LEVEL_W-1:0];
				REG_UV_TRIP:     cfg_q.trip_level    <= cfg_data[LEVEL_W-1:0];
				REG_UV_RECOVER:  cfg_q.recover_level <= cfg_data[LEVEL_W-1:0];
				REG_OC_DEBOUNCE: cfg_q.oc_ticks      <= cfg_data[TICKS_W-1:0];
				REG_UV_DEBOUNCE: cfg_q.uv_ticks      <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- src/pfm_debounce.sv -----
module pfm_debounce #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         verdict,
	input  logic [pfm_pkg::TICKS_W-1:0]  ticks,
	output pfm_pkg::det_status_t         status
);
	import pfm_pkg::*;

	localparam int CMP_W = (TICK_COUNT_BITS > TICKS_W) ? TICK_COUNT_BITS : TICKS_W;

	logic                       state_q;
	logic                       pend_q;
	logic [TICK_COUNT_BITS-1:0] elapsed_q;

	logic                       state_n;
	logic                       pend_n;
	logic [TICK_COUNT_BITS-1:0] elapsed_n;
	logic [TICK_COUNT_BITS-1:0] elapsed_inc;

	// Saturate instead of wrapping
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		state_n   = state_q;
		pend_n    = pend_q;
		elapsed_n = elapsed_q;
		if (verdict == state_q) begin
			pend_n = state_q;
		end else if (verdict != pend_q) begin
			// new candidate: restart the timer
			pend_n    = verdict;
			elapsed_n = '0;
		end else begin
			elapsed_n = elapsed_inc;
			if (CMP_W'(elapsed_inc) >= CMP_W'(ticks)) begin
				state_n = verdict;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= 1'b0;
			pend_q    <= 1'b0;
			elapsed_q <= '0;
		end else if (step) begin
			state_q   <= state_n;
			pend_q    <= pend_n;
			elapsed_q <= elapsed_n;
		end
	end

	assign status.state      = state_q;
	assign status.next_state = state_n;

endmodule

// ----- src/power_fault_monitor_unit.sv -----
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tuser: kind; tdata: four sample codes, request_on
// m_       out  m_tvalid/m_tready    tdata: fault_bits, drive_enable, lidar_enable
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready holds high; every input beat gives
// exactly one result beat. Input register, then the detector and fault update into
// the result register. The detector state loop closes through the debounce registers.
// Reset clears the detectors, the faults, the requests and both valid flags.
// A stalled result holds in the result register while one more beat waits in the
// input register; s_tready drops only when both are full.
module power_fault_monitor_unit #(
	parameter int SAMPLE_BITS     = 12,
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// kind
	input  logic [pfm_pkg::KIND_W-1:0]                 s_tuser,
	// signal_current_code, drive_current_code, signal_voltage_filtered,
	// drive_voltage_filtered, request_on, zero fill
	input  logic [((4*SAMPLE_BITS+1+7)/8)*8-1:0]       s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// fault_bits, drive_enable, lidar_enable, zero fill
	output logic [pfm_pkg::OUT_DATA_W-1:0]             m_tdata,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [pfm_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [pfm_pkg::CFG_DATA_W-1:0]             cfg_data
);
	import pfm_pkg::*;

	localparam int SB = SAMPLE_BITS;

	pfm_cfg_t cfg;

	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [SB-1:0]       sig_cur_s1;
	logic [SB-1:0]       drv_cur_s1;
	logic [SB-1:0]       sig_volt_s1;
	logic [SB-1:0]       drv_volt_s1;
	logic                req_s1;

	logic                valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	logic [FAULT_W-1:0]  fault_q;
	logic                drive_req_q;
	logic                lidar_q;

	logic                advance;
	logic                tick;
	logic [NUM_DET-1:0]  verdict;
	logic [TICKS_W-1:0]  det_ticks [NUM_DET];
	det_status_t         det [NUM_DET];

	logic [FAULT_W-1:0]  fault_n;
	logic                drive_req_n;
	logic                lidar_n;
	logic                drive_en_n;

	pfm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign tick     = advance && (kind_s1 == KIND_TICK);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1     <= s_tuser;
			sig_cur_s1  <= s_tdata[SB-1:0];
			drv_cur_s1  <= s_tdata[2*SB-1:SB];
			sig_volt_s1 <= s_tdata[3*SB-1:2*SB];
			drv_volt_s1 <= s_tdata[4*SB-1:3*SB];
			req_s1      <= s_tdata[4*SB];
		end
	end

	// Raw verdicts; undervoltage level depends on the detector's present state
	assign verdict[DET_SIG_OC] = sig_cur_s1 > SB'(cfg.sig_limit);
	assign verdict[DET_DRV_OC] = drv_cur_s1 > SB'(cfg.drv_limit);
	assign verdict[DET_SIG_UV] = sig_volt_s1 <
		SB'(det[DET_SIG_UV].state ? cfg.recover_level : cfg.trip_level);
	assign verdict[DET_DRV_UV] = drv_volt_s1 <
		SB'(det[DET_DRV_UV].state ? cfg.recover_level : cfg.trip_level);

	assign det_ticks[DET_SIG_OC] = cfg.oc_ticks;
	assign det_ticks[DET_DRV_OC] = cfg.oc_ticks;
	assign det_ticks[DET_SIG_UV] = cfg.uv_ticks;
	assign det_ticks[DET_DRV_UV] = cfg.uv_ticks;

	for (genvar d = 0; d < NUM_DET; d++) begin : g_det
		pfm_debounce #(
			.TICK_COUNT_BITS (TICK_COUNT_BITS)
		) u_deb (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (tick),
			.verdict (verdict[d]),
			.ticks   (det_ticks[d]),
			.status  (det[d])
		);
	end

	always_comb begin
		fault_n     = fault_q;
		drive_req_n = drive_req_q;
		lidar_n     = lidar_q;
		case (kind_s1)
			KIND_TICK: begin
				// overcurrent latches, undervoltage follows
				fault_n[DET_SIG_OC] = fault_q[DET_SIG_OC] | det[DET_SIG_OC].next_state;
				fault_n[DET_DRV_OC] = fault_q[DET_DRV_OC] | det[DET_DRV_OC].next_state;
				fault_n[DET_SIG_UV] = det[DET_SIG_UV].next_state;
				fault_n[DET_DRV_UV] = det[DET_DRV_UV].next_state;
				if (det[DET_SIG_OC].next_state) begin
					lidar_n = 1'b0;
				end
			end
			KIND_DRIVE: begin
				drive_req_n = req_s1;
			end
			KIND_LIDAR: begin
				lidar_n = req_s1 && !fault_q[DET_SIG_OC];
			end
			default: ;
		endcase
	end

	assign drive_en_n = drive_req_n && !fault_n[DET_SIG_OC] && !fault_n[DET_DRV_OC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= '0;
			drive_req_q <= 1'b0;
			lidar_q     <= 1'b0;
		end else if (advance) begin
			fault_q     <= fault_n;
			drive_req_q <= drive_req_n;
			lidar_q     <= lidar_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {(OUT_DATA_W - FAULT_W - 2)'(0), lidar_n, drive_en_n, fault_n};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule

// ----- src/pfm_checker.sv -----
module pfm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pfm_pkg::OUT_DATA_W-1:0] m_tdata
);
	import pfm_pkg::*;

	// drive enable never shown together with an overcurrent fault
	a_drive_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[OUT_DRV_EN_BIT] &&
			(m_tdata[DET_SIG_OC] || m_tdata[DET_DRV_OC])))
		else $error("drive enable with overcurrent fault");

	a_lidar_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[OUT_LIDAR_BIT] && m_tdata[DET_SIG_OC]))
		else $error("lidar enable with signal overcurrent");

	// overcurrent faults latch until reset
	a_oc_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[DET_SIG_OC] || m_tdata[DET_DRV_OC])) |=>
			((m_tdata[DET_SIG_OC] || !$past(m_tdata[DET_SIG_OC])) &&
			 (m_tdata[DET_DRV_OC] || !$past(m_tdata[DET_DRV_OC]))))
		else $error("overcurrent fault cleared without reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result beat changed");

endmodule

bind power_fault_monitor_unit pfm_checker u_pfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- test/tb_power_fault_monitor_unit.sv -----
module tb_power_fault_monitor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pfm_pkg::*;

	localparam int SB          = 12;
	localparam int S_DATA_W    = ((4*SB+1+7)/8)*8;
	localparam int LEVEL_MAX   = 4095;
	localparam int CYCLE_LIMIT = 1_000_000;

	// Kind 3 and index 6 are not decoded by the block
	localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd6;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] sig_cur;
		logic [LEVEL_W-1:0] drv_cur;
		logic [LEVEL_W-1:0] sig_volt;
		logic [LEVEL_W-1:0] drv_volt;
		logic               req;
	} mon_item_t;

	typedef struct {
		logic [FAULT_W-1:0] faults;
		logic               drv_en;
		logic               lidar_en;
	} mon_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [KIND_W-1:0]     s_tuser;
	// signal_current_code, drive_current_code, signal_voltage_filtered,
	// drive_voltage_filtered, request_on, zero fill
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// fault_bits, drive_enable, lidar_enable, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Monitor state as predicted
	pfm_cfg_t           cfg_m;
	logic               det_state   [NUM_DET];
	logic               det_pend    [NUM_DET];
	logic [TICKS_W-1:0] det_elapsed [NUM_DET];
	logic [FAULT_W-1:0] fault_reg;
	logic               drive_req;
	logic               lidar_pin;

	mon_out_t status_q[$];

	bit send_gaps;
	bit sink_stalls;
	int hold_cycles;
	int volt_zone   [2];
	int volt_run    [2];
	int glitch_left [2];

	int fail_count;
	int cycle_count;
	int n_ticks;
	int n_requests;
	int n_unused;
	int n_writes;
	int n_results;

	power_fault_monitor_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[power_fault_monitor_unit] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic debounce_detector(input int slot, input logic verdict,
			input logic [TICKS_W-1:0] ticks);
		if (verdict == det_state[slot]) begin
			det_pend[slot] = det_state[slot];
		end else if (verdict != det_pend[slot]) begin
			det_pend[slot]    = verdict;
			det_elapsed[slot] = '0;
		end else begin
			// count saturates instead of wrapping
			if (det_elapsed[slot] != '1)
				det_elapsed[slot] = det_elapsed[slot] + 1'b1;
			if (det_elapsed[slot] >= ticks)
				det_state[slot] = verdict;
		end
		return det_state[slot];
	endfunction

	function automatic logic under_level(input int slot, input logic [LEVEL_W-1:0] volt);
		logic [LEVEL_W-1:0] level;
		level = det_state[slot] ? cfg_m.recover_level : cfg_m.trip_level;
		return volt < level;
	endfunction

	function automatic mon_out_t monitor_step(input mon_item_t it);
		mon_out_t r;
		case (it.kind)
		KIND_TICK: begin
			if (debounce_detector(DET_SIG_OC, it.sig_cur > cfg_m.sig_limit,
					cfg_m.oc_ticks)) begin
				fault_reg[DET_SIG_OC] = 1'b1;
				lidar_pin             = 1'b0;
			end
			if (debounce_detector(DET_DRV_OC, it.drv_cur > cfg_m.drv_limit, cfg_m.oc_ticks))
				fault_reg[DET_DRV_OC] = 1'b1;
			fault_reg[DET_SIG_UV] = debounce_detector(DET_SIG_UV,
				under_level(DET_SIG_UV, it.sig_volt), cfg_m.uv_ticks);
			fault_reg[DET_DRV_UV] = debounce_detector(DET_DRV_UV,
				under_level(DET_DRV_UV, it.drv_volt), cfg_m.uv_ticks);
		end
		KIND_DRIVE: drive_req = it.req;
		KIND_LIDAR: lidar_pin = it.req && !fault_reg[DET_SIG_OC];
		default: ;
		endcase
		r.faults   = fault_reg;
		r.drv_en   = drive_req && !fault_reg[DET_SIG_OC] && !fault_reg[DET_DRV_OC];
		r.lidar_en = lidar_pin;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	function automatic mon_item_t mk_item(input logic [KIND_W-1:0] k, input int sc,
			input int dc, input int sv, input int dv, input bit rq);
		mon_item_t it;
		it.kind     = k;
		it.sig_cur  = LEVEL_W'(sc);
		it.drv_cur  = LEVEL_W'(dc);
		it.sig_volt = LEVEL_W'(sv);
		it.drv_volt = LEVEL_W'(dv);
		it.req      = rq;
		return it;
	endfunction

	task automatic send_item(input mon_item_t it);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {{(S_DATA_W-4*SB-1){1'b0}}, it.req, it.drv_volt, it.sig_volt,
			it.drv_cur, it.sig_cur};
		do @(posedge clk); while (!s_tready);
		status_q.push_back(monitor_step(it));
		case (it.kind)
		KIND_TICK:               n_ticks++;
		KIND_DRIVE, KIND_LIDAR:  n_requests++;
		default:                 n_unused++;
		endcase
	endtask

	task automatic tick(input int sc, input int dc, input int sv, input int dv);
		send_item(mk_item(KIND_TICK, sc, dc, sv, dv, 1'b0));
	endtask

	// Drop valid and wait for every outstanding beat to come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_SIG_LIMIT:   cfg_m.sig_limit     = val[LEVEL_W-1:0];
		REG_DRV_LIMIT:   cfg_m.drv_limit     = val[LEVEL_W-1:0];
		REG_UV_TRIP:     cfg_m.trip_level    = val[LEVEL_W-1:0];
		REG_UV_RECOVER:  cfg_m.recover_level = val[LEVEL_W-1:0];
		REG_OC_DEBOUNCE: cfg_m.oc_ticks      = val;
		REG_UV_DEBOUNCE: cfg_m.uv_ticks      = val;
		default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_writes++;
	endtask

	// Voltage near the hysteresis band: below both levels, between, above, or anywhere
	function automatic logic [LEVEL_W-1:0] pick_volt(input int zone);
		int lo;
		int hi;
		lo = (cfg_m.trip_level < cfg_m.recover_level) ? int'(cfg_m.trip_level) :
			int'(cfg_m.recover_level);
		hi = (cfg_m.trip_level < cfg_m.recover_level) ? int'(cfg_m.recover_level) :
			int'(cfg_m.trip_level);
		case (zone)
		0: if (lo > 0) return LEVEL_W'($urandom_range(0, lo - 1));
		1: if (hi > lo) return LEVEL_W'($urandom_range(lo, hi - 1));
		2: return LEVEL_W'($urandom_range(hi, LEVEL_MAX));
		default: ;
		endcase
		return LEVEL_W'($urandom_range(0, LEVEL_MAX));
	endfunction

	// Mostly under the limit, with over-limit glitches of at most glitch_max ticks;
	// one under-limit tick always follows a glitch
	function automatic logic [LEVEL_W-1:0] pick_current(input int rail, input int limit,
			input int glitch_max);
		if (glitch_left[rail] < 0) begin
			glitch_left[rail] = 0;
			return LEVEL_W'($urandom_range(0, limit));
		end
		if (glitch_left[rail] == 0 && glitch_max > 0 && limit < LEVEL_MAX &&
				$urandom_range(0, 15) == 0)
			glitch_left[rail] = $urandom_range(1, glitch_max);
		if (glitch_left[rail] > 0) begin
			glitch_left[rail]--;
			if (glitch_left[rail] == 0)
				glitch_left[rail] = -1;
			return LEVEL_W'($urandom_range(limit + 1, LEVEL_MAX));
		end
		return LEVEL_W'($urandom_range(0, limit));
	endfunction

	task automatic random_items(input int count, input int sig_glitch_max, input int drv_glitch_max);
		int pick;
		logic [KIND_W-1:0] k;
		repeat (count) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				for (int r = 0; r < 2; r++) begin
					if (volt_run[r] == 0) begin
						volt_zone[r] = $urandom_range(0, 3);
						volt_run[r]  = $urandom_range(1, 12);
					end
					volt_run[r]--;
				end
				send_item(mk_item(KIND_TICK,
					pick_current(0, int'(cfg_m.sig_limit), sig_glitch_max),
					pick_current(1, int'(cfg_m.drv_limit), drv_glitch_max),
					pick_volt(volt_zone[0]), pick_volt(volt_zone[1]),
					1'($urandom_range(0, 1))));
			end else begin
				k = (pick < 17) ? KIND_DRIVE : (pick < 19) ? KIND_LIDAR : KIND_UNUSED;
				send_item(mk_item(k, $urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX),
					$urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX),
					1'($urandom_range(0, 1))));
			end
		end
		// start the next phase on an under-limit tick
		glitch_left[0] = -1;
		glitch_left[1] = -1;
	endtask

	// ---------------------------------------------------------------- result side

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		mon_out_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (status_q.size() == 0) begin
				$error("result beat %h with nothing expected", m_tdata);
				fail_count++;
			end else begin
				want = status_q.pop_front();
				if (m_tdata[FAULT_W-1:0] !== want.faults) begin
					$error("fault_bits: expected %h, got %h", want.faults, m_tdata[FAULT_W-1:0]);
					fail_count++;
				end
				if (m_tdata[OUT_DRV_EN_BIT] !== want.drv_en) begin
					$error("drive_enable: expected %b, got %b", want.drv_en,
						m_tdata[OUT_DRV_EN_BIT]);
					fail_count++;
				end
				if (m_tdata[OUT_LIDAR_BIT] !== want.lidar_en) begin
					$error("lidar_enable: expected %b, got %b", want.lidar_en,
						m_tdata[OUT_LIDAR_BIT]);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Reset values: limits at full scale and levels at zero, so nothing can fault
	task automatic test_defaults();
		send_item(mk_item(KIND_UNUSED, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(KIND_UNUSED, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 1'b1));
		tick(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
		tick(0, 0, 0, 0);
		send_item(mk_item(KIND_DRIVE, 0, 0, 0, 0, 1'b1));
		send_item(mk_item(KIND_LIDAR, LEVEL_MAX, 0, LEVEL_MAX, 0, 1'b1));
		send_item(mk_item(KIND_TICK, 0, 0, 0, 0, 1'b1));
		send_item(mk_item(KIND_LIDAR, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(KIND_DRIVE, 0, 0, 0, 0, 1'b0));
		send_item(mk_item(KIND_LIDAR, 0, 0, 0, 0, 1'b1));
		send_item(mk_item(KIND_DRIVE, 0, 0, 0, 0, 1'b1));
	endtask

	// Trip below one level, hold until the higher recovery level is reached
	task automatic test_undervolt_hysteresis();
		settle();
		write_reg(REG_UV_TRIP, 16'hF3E8);      // upper bits dropped: 1000
		write_reg(REG_UV_RECOVER, 16'd1200);
		tick(0, 0, 999, LEVEL_MAX);
		tick(0, 0, 999, LEVEL_MAX);
		tick(0, 0, 1100, 0);
		tick(0, 0, 1200, 0);
		send_item(mk_item(KIND_UNUSED, 0, 0, 0, 0, 1'b1));
		tick(0, 0, 1200, 1199);
		tick(0, 0, 0, 1200);
		tick(0, 0, LEVEL_MAX, 1200);
		settle();
		write_reg(REG_UV_DEBOUNCE, 16'd2);
		repeat (3) tick(0, 0, 0, LEVEL_MAX);
		repeat (3) tick(0, 0, LEVEL_MAX, LEVEL_MAX);
	endtask

	// Long debounce setting: the verdict has to hold for the whole count
	task automatic test_slow_debounce();
		settle();
		send_gaps   = 1'b0;
		sink_stalls = 1'b0;
		write_reg(REG_UV_TRIP, 16'd100);
		write_reg(REG_UV_DEBOUNCE, 16'd40);
		repeat (42)
			tick($urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX), 0, LEVEL_MAX);
		settle();
		write_reg(REG_UV_DEBOUNCE, 16'd0);
		repeat (2) tick(0, 0, LEVEL_MAX, LEVEL_MAX);
	endtask

	// Receiver holds off while the sender keeps offering, so the input side stalls
	task automatic test_backpressure();
		settle();
		send_gaps   = 1'b0;
		hold_cycles = 150;
		random_items(12, 0, 0);
		settle();
	endtask

	// Random traffic around the undervoltage levels; overcurrent glitches stay short
	task automatic test_random_undervolt();
		settle();
		send_gaps   = 1'b1;
		sink_stalls = 1'b1;
		write_reg(REG_SIG_LIMIT, 16'd3000);
		write_reg(REG_DRV_LIMIT, 16'd3500);
		write_reg(REG_UV_TRIP, 16'd2000);
		write_reg(REG_UV_RECOVER, 16'd2200);
		write_reg(REG_OC_DEBOUNCE, 16'hFFFF);
		write_reg(REG_UV_DEBOUNCE, 16'd0);
		random_items(150, 3, 3);

		// recovery level under the trip level
		settle();
		sink_stalls = 1'b0;
		write_reg(REG_UV_TRIP, 16'd1500);
		write_reg(REG_UV_RECOVER, 16'd1000);
		write_reg(REG_OC_DEBOUNCE, 16'd3);
		write_reg(REG_UV_DEBOUNCE, 16'd3);
		random_items(150, 3, 3);

		settle();
		send_gaps   = 1'b0;
		sink_stalls = 1'b1;
		write_reg(REG_SIG_LIMIT, 16'd2048);
		write_reg(REG_DRV_LIMIT, 16'd2048);
		write_reg(REG_UV_TRIP, 16'hFFFF);
		write_reg(REG_UV_RECOVER, 16'd0);
		write_reg(REG_UV_DEBOUNCE, 16'd1);
		write_reg(REG_UNUSED, 16'hFFFF);
		random_items(100, 3, 3);
	endtask

	// Drive overcurrent latches and blocks the drive enable for good
	task automatic test_drive_overcurrent();
		settle();
		send_gaps   = 1'b1;
		sink_stalls = 1'b1;
		write_reg(REG_DRV_LIMIT, 16'd0);
		write_reg(REG_OC_DEBOUNCE, 16'd5);
		write_reg(REG_UV_TRIP, 16'd1800);
		write_reg(REG_UV_RECOVER, 16'd2600);
		write_reg(REG_UV_DEBOUNCE, 16'd2);
		send_item(mk_item(KIND_DRIVE, 0, 0, 0, 0, 1'b1));
		random_items(120, 3, 12);
		repeat (7) tick(0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
		send_item(mk_item(KIND_DRIVE, 0, 0, 0, 0, 1'b1));
		send_item(mk_item(KIND_LIDAR, 0, 0, 0, 0, 1'b1));
	endtask

	// Signal overcurrent latches, forces the LiDAR supply off and refuses its request
	task automatic test_signal_overcurrent();
		settle();
		write_reg(REG_SIG_LIMIT, 16'd1000);
		write_reg(REG_OC_DEBOUNCE, 16'd0);
		send_item(mk_item(KIND_LIDAR, 0, 0, 0, 0, 1'b1));
		tick(1001, 0, LEVEL_MAX, LEVEL_MAX);
		tick(1001, 0, LEVEL_MAX, LEVEL_MAX);
		send_item(mk_item(KIND_LIDAR, 0, 0, 0, 0, 1'b1));
		tick(1000, 0, LEVEL_MAX, LEVEL_MAX);
		tick(0, 0, LEVEL_MAX, LEVEL_MAX);
		send_item(mk_item(KIND_LIDAR, 0, 0, 0, 0, 1'b1));
		random_items(120, 12, 12);
	endtask

	task automatic test_final_stream();
		settle();
		send_gaps   = 1'b0;
		sink_stalls = 1'b0;
		write_reg(REG_UV_TRIP, 16'd3000);
		write_reg(REG_UV_RECOVER, 16'd3500);
		write_reg(REG_UV_DEBOUNCE, 16'd0);
		random_items(100, 12, 12);
		settle();
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = '0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		send_gaps   = 1'b1;
		sink_stalls = 1'b1;
		hold_cycles = 0;
		cfg_m.sig_limit     = LEVEL_MAX;
		cfg_m.drv_limit     = LEVEL_MAX;
		cfg_m.trip_level    = '0;
		cfg_m.recover_level = '0;
		cfg_m.oc_ticks      = '0;
		cfg_m.uv_ticks      = '0;
		for (int i = 0; i < NUM_DET; i++) begin
			det_state[i]   = 1'b0;
			det_pend[i]    = 1'b0;
			det_elapsed[i] = '0;
		end
		for (int r = 0; r < 2; r++) begin
			volt_zone[r]   = 0;
			volt_run[r]    = 0;
			glitch_left[r] = 0;
		end
		fault_reg = '0;
		drive_req = 1'b0;
		lidar_pin = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_defaults();
		test_undervolt_hysteresis();
		test_slow_debounce();
		test_backpressure();
		test_random_undervolt();
		test_drive_overcurrent();
		test_signal_overcurrent();
		test_final_stream();
		repeat (10) @(posedge clk);

		$display("Ran %0d update ticks, %0d supply requests and %0d undecoded beats",
			n_ticks, n_requests, n_unused);
		$display("over %0d register writes; checked %0d result beats, %0d field mismatches",
			n_writes, n_results, fail_count);
		if (fail_count == 0)
			$display("[power_fault_monitor_unit] OK");
		else
			$display("[power_fault_monitor_unit] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/pfm_pkg.sv
src/pfm_cfg_regs.sv
src/pfm_debounce.sv
src/power_fault_monitor_unit.sv
src/pfm_checker.sv
test/tb_power_fault_monitor_unit.sv
